FILE: rtl/core/text_console_cursor_controller_core_macros.svh
// Assertion macros for the console cursor controller.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TEXT_CONSOLE_CURSOR_CONTROLLER_CORE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_CONTROLLER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCCC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tccc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TCCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tccc assertion failed");

`endif

FILE: rtl/core/tccc_pkg.sv
`timescale 1ns / 1ps

package tccc_pkg;

  localparam int ORIGIN_X_W = 14;
  localparam int ORIGIN_Y_W = 15;

  localparam logic [1:0] MODE_CHAR   = 2'd0;
  localparam logic [1:0] MODE_SETPOS = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_BS  = 8'd8;

  localparam logic [8:0] TAB_STEP = 9'd8;
  localparam logic [8:0] TAB_MASK = ~9'd7;

  localparam logic [1:0] REG_MAX_COLS   = 2'd0;
  localparam logic [1:0] REG_MAX_ROWS   = 2'd1;
  localparam logic [1:0] REG_FONT_SCALE = 2'd2;

  localparam logic [7:0] MAX_COLS_RST   = 8'd80;
  localparam logic [7:0] MAX_ROWS_RST   = 8'd25;
  localparam logic [3:0] FONT_SCALE_RST = 4'd1;

  typedef struct packed {
    logic [7:0] max_cols;
    logic [7:0] max_rows;
    logic [3:0] font_scale;
  } cfg_t;

  typedef struct packed {
    logic                  draw;
    logic [7:0]            glyph_code;
    logic [ORIGIN_X_W-1:0] origin_x;
    logic [ORIGIN_Y_W-1:0] origin_y;
    logic                  clear_screen;
    logic [7:0]            cursor_row;
    logic [7:0]            cursor_col;
  } res_t;

endpackage

FILE: rtl/core/tccc_step.sv
`timescale 1ns / 1ps

module tccc_step #(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 16
) (
  input  logic [1:0]     mode,
  input  logic [7:0]     char_code,
  input  logic [7:0]     target_row,
  input  logic [7:0]     target_col,
  input  logic [7:0]     cursor_row,
  input  logic [7:0]     cursor_col,
  input  tccc_pkg::cfg_t cfg,
  output tccc_pkg::res_t res
);

  localparam int XW = 12 + $clog2(GLYPH_WIDTH + 1);
  localparam int YW = 12 + $clog2(GLYPH_HEIGHT + 1);

  logic [7:0]    eff_cols;
  logic [7:0]    eff_rows;
  logic [7:0]    row_inc;
  logic [7:0]    nl_row;
  logic [8:0]    tab_col;
  logic [8:0]    inc_col;
  logic [7:0]    col_lim;
  logic [7:0]    row_lim;
  logic [XW-1:0] prod_x;
  logic [YW-1:0] prod_y;

  assign eff_cols = (cfg.max_cols == 8'd0) ? 8'd1 : cfg.max_cols;
  assign eff_rows = (cfg.max_rows == 8'd0) ? 8'd1 : cfg.max_rows;
  assign col_lim  = eff_cols - 8'd1;
  assign row_lim  = eff_rows - 8'd1;
  assign row_inc  = cursor_row + 8'd1;
  assign nl_row   = (row_inc >= eff_rows) ? 8'd0 : row_inc;
  assign tab_col  = ({1'b0, cursor_col} + tccc_pkg::TAB_STEP) & tccc_pkg::TAB_MASK;
  assign inc_col  = {1'b0, cursor_col} + 9'd1;

  assign prod_x = XW'(cursor_col) * XW'(cfg.font_scale) * XW'(GLYPH_WIDTH);
  assign prod_y = YW'(cursor_row) * YW'(cfg.font_scale) * YW'(GLYPH_HEIGHT);

  always_comb begin
    res              = '0;
    res.cursor_row   = cursor_row;
    res.cursor_col   = cursor_col;
    unique case (mode)
      tccc_pkg::MODE_CHAR: begin
        unique case (char_code)
          tccc_pkg::CH_CR: begin
            res.cursor_col = 8'd0;
          end
          tccc_pkg::CH_LF: begin
            res.cursor_col = 8'd0;
            res.cursor_row = nl_row;
          end
          tccc_pkg::CH_TAB: begin
            if (tab_col >= {1'b0, eff_cols}) begin
              res.cursor_col = 8'd0;
              res.cursor_row = nl_row;
            end else begin
              res.cursor_col = tab_col[7:0];
            end
          end
          tccc_pkg::CH_BS: begin
            if (cursor_col == 8'd0) begin
              res.cursor_col = col_lim;
              res.cursor_row = (cursor_row != 8'd0) ? (cursor_row - 8'd1) : 8'd0;
            end else begin
              res.cursor_col = cursor_col - 8'd1;
            end
          end
          default: begin
            res.draw       = 1'b1;
            res.glyph_code = char_code;
            res.origin_x   = prod_x[tccc_pkg::ORIGIN_X_W-1:0];
            res.origin_y   = prod_y[tccc_pkg::ORIGIN_Y_W-1:0];
            if (inc_col >= {1'b0, eff_cols}) begin
              res.cursor_col = 8'd0;
              res.cursor_row = nl_row;
            end else begin
              res.cursor_col = inc_col[7:0];
            end
          end
        endcase
      end
      tccc_pkg::MODE_SETPOS: begin
        res.cursor_row = (target_row > row_lim) ? row_lim : target_row;
        res.cursor_col = (target_col > col_lim) ? col_lim : target_col;
      end
      tccc_pkg::MODE_CLEAR: begin
        res.cursor_row   = 8'd0;
        res.cursor_col   = 8'd0;
        res.clear_screen = 1'b1;
      end
      default: begin
        res.cursor_row = cursor_row;
      end
    endcase
  end

endmodule

FILE: rtl/core/text_console_cursor_controller_core.sv
`timescale 1ns / 1ps
// Cursor controller for a character-cell text console without scrolling.
// Input beats carry a character, a set-position request or a clear request;
// the kind travels in in_tuser. Every input beat yields exactly one output
// beat with the cursor after the item, a glyph draw command for every code
// other than CR, LF, tab and backspace, and a clear flag for clear requests.
// An input beat lands in an input register; the step logic between that
// register and the output register updates the cursor, and the result is
// held in the output register until the receiver takes it.
// One item is taken every cycle while out_tready stays high; the rate is set
// by the single cursor update between the two registers.
// When the receiver stalls, the output beat holds and the input register
// still takes one more beat; after that in_tready drops until a beat leaves.
// Configuration writes on the cfg channel are always taken and must only be
// issued while no item is in flight.
// Reset clears the cursor to row 0, column 0, loads 80 columns, 25 rows and
// scale 1, and empties both registers.

`include "text_console_cursor_controller_core_macros.svh"

module text_console_cursor_controller_core #(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code, target_row, target_col
  input  logic [1:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // glyph_code, origin_x, origin_y, cursor_row_out,
                                  // cursor_col_out, zero pad
  output logic [1:0]  out_tuser,  // draw, clear_screen
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic           in_v_r;
  logic [1:0]     in_mode_r;
  logic [7:0]     in_char_r;
  logic [7:0]     in_trow_r;
  logic [7:0]     in_tcol_r;
  logic [7:0]     cursor_row_r;
  logic [7:0]     cursor_col_r;
  tccc_pkg::cfg_t cfg_r;
  logic           out_v_r;
  tccc_pkg::res_t out_res_r;
  tccc_pkg::res_t out_res_nxt;
  logic           out_adv;
  logic           step_fire;

  assign cfg_ready = 1'b1;
  assign out_adv   = !out_v_r || out_tready;
  assign step_fire = in_v_r && out_adv;
  assign in_tready = !in_v_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_cols   <= tccc_pkg::MAX_COLS_RST;
      cfg_r.max_rows   <= tccc_pkg::MAX_ROWS_RST;
      cfg_r.font_scale <= tccc_pkg::FONT_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tccc_pkg::REG_MAX_COLS:   cfg_r.max_cols   <= cfg_data;
        tccc_pkg::REG_MAX_ROWS:   cfg_r.max_rows   <= cfg_data;
        tccc_pkg::REG_FONT_SCALE: cfg_r.font_scale <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_mode_r <= in_tuser;
      in_char_r <= in_tdata[7:0];
      in_trow_r <= in_tdata[15:8];
      in_tcol_r <= in_tdata[23:16];
    end
  end

  tccc_step #(
    .GLYPH_WIDTH (GLYPH_WIDTH),
    .GLYPH_HEIGHT(GLYPH_HEIGHT)
  ) u_step (
    .mode      (in_mode_r),
    .char_code (in_char_r),
    .target_row(in_trow_r),
    .target_col(in_tcol_r),
    .cursor_row(cursor_row_r),
    .cursor_col(cursor_col_r),
    .cfg       (cfg_r),
    .res       (out_res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r      <= 1'b0;
      cursor_row_r <= 8'd0;
      cursor_col_r <= 8'd0;
    end else begin
      if (out_adv) begin
        out_v_r <= in_v_r;
      end
      if (step_fire) begin
        cursor_row_r <= out_res_nxt.cursor_row;
        cursor_col_r <= out_res_nxt.cursor_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = {out_res_r.clear_screen, out_res_r.draw};
  assign out_tdata  = {3'b000, out_res_r.cursor_col, out_res_r.cursor_row,
                       out_res_r.origin_y, out_res_r.origin_x, out_res_r.glyph_code};

  `TCCC_ASSERT_SAME(a_cursor_matches_out, out_v_r,
    cursor_row_r == out_res_r.cursor_row && cursor_col_r == out_res_r.cursor_col)
  `TCCC_ASSERT_SAME(a_clear_homes, out_v_r && out_res_r.clear_screen,
    out_res_r.cursor_row == 8'd0 && out_res_r.cursor_col == 8'd0 && !out_res_r.draw)
  `TCCC_ASSERT_SAME(a_no_draw_zero, out_v_r && !out_res_r.draw,
    out_res_r.glyph_code == 8'd0 && out_res_r.origin_x == '0 && out_res_r.origin_y == '0)
  `TCCC_ASSERT_SAME(a_stall_full, !in_tready, in_v_r && out_v_r && !out_tready)

endmodule
